// ===== src/vertex_to_window_transform_top_macros.svh =====
// Assertion macros shared by the vertex to window transform RTL.
`ifndef VERTEX_TO_WINDOW_TRANSFORM_TOP_MACROS_SVH
`define VERTEX_TO_WINDOW_TRANSFORM_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VTW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VTW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/vtw_pkg.sv =====
// Types and constants of the vertex to window transform.
`default_nettype none

package vtw_pkg;

    localparam int DIV_STEPS = 20;
    localparam int NUM_W     = 54;
    localparam int DEN_W     = 34;
    localparam int T_W       = 34;
    localparam int LATENCY   = 5 + DIV_STEPS;
    localparam int OUT_MAX   = 131071;
    localparam int OUT_MIN   = -131072;
    localparam logic [15:0] COEF_ONE = 16'd2048;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_WZERO = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5,
        REG_LEFT   = 3'd6,
        REG_BOTTOM = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                 zero;
        logic                 neg_x;
        logic                 neg_y;
        logic                 ovf_x;
        logic                 ovf_y;
        logic [NUM_W-1:0]     rem_x;
        logic [NUM_W-1:0]     rem_y;
        logic [DEN_W-1:0]     den;
        logic [DIV_STEPS-1:0] q_x;
        logic [DIV_STEPS-1:0] q_y;
    } t_div;

endpackage

`default_nettype wire

// ===== src/vertex_to_window_transform_top.sv =====
// Top level of the vertex to window transform pipeline.
`default_nettype none
`include "vertex_to_window_transform_top_macros.svh"

// Takes one point per clock cycle whenever start is high; busy is always low.
// Each item leaves 25 cycles after it was taken, shown for one cycle with
// o_done high, and the receiver must take it then. The latency is set by four
// stages of matrix multiply and setup, a 20-stage divider that yields one
// quotient bit per stage, and one stage of offset and clamping.
module vertex_to_window_transform_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic signed [15:0] i_pz,
    input  logic signed [15:0] i_pw,
    output logic               o_done,
    output logic signed [17:0] o_win_x,
    output logic signed [17:0] o_win_y,
    output logic [1:0]         o_status
);

    localparam int NW = vtw_pkg::NUM_W;
    localparam int DW = vtw_pkg::DEN_W;
    localparam int DS = vtw_pkg::DIV_STEPS;
    localparam int TW = vtw_pkg::T_W;

    logic [63:0]        r_row [4];
    logic [11:0]        r_vw;
    logic [11:0]        r_vh;
    logic signed [12:0] r_left;
    logic signed [12:0] r_bottom;

    vtw_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = vtw_pkg::t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_row[i] <= 64'(vtw_pkg::COEF_ONE) << (16 * i);
            end
            r_vw     <= 12'd640;
            r_vh     <= 12'd480;
            r_left   <= '0;
            r_bottom <= '0;
        end else if (w_wr) begin
            case (w_idx)
                vtw_pkg::REG_ROW0:   r_row[0] <= pwdata;
                vtw_pkg::REG_ROW1:   r_row[1] <= pwdata;
                vtw_pkg::REG_ROW2:   r_row[2] <= pwdata;
                vtw_pkg::REG_ROW3:   r_row[3] <= pwdata;
                vtw_pkg::REG_WIDTH:  r_vw     <= pwdata[11:0];
                vtw_pkg::REG_HEIGHT: r_vh     <= pwdata[11:0];
                vtw_pkg::REG_LEFT:   r_left   <= pwdata[12:0];
                vtw_pkg::REG_BOTTOM: r_bottom <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            vtw_pkg::REG_ROW0:   prdata = r_row[0];
            vtw_pkg::REG_ROW1:   prdata = r_row[1];
            vtw_pkg::REG_ROW2:   prdata = r_row[2];
            vtw_pkg::REG_ROW3:   prdata = r_row[3];
            vtw_pkg::REG_WIDTH:  prdata = {52'd0, r_vw};
            vtw_pkg::REG_HEIGHT: prdata = {52'd0, r_vh};
            vtw_pkg::REG_LEFT:   prdata = {51'd0, r_left};
            vtw_pkg::REG_BOTTOM: prdata = {51'd0, r_bottom};
            default:             prdata = '0;
        endcase
    end

    logic [14:0] w_hw;
    logic [14:0] w_hh;
    assign w_hw = {r_vw, 3'b000};
    assign w_hh = {r_vh, 3'b000};

    // Stage 1: the twelve products that feed the x, y and w columns.
    logic signed [15:0] w_p [4];
    assign w_p[0] = i_px;
    assign w_p[1] = i_py;
    assign w_p[2] = i_pz;
    assign w_p[3] = i_pw;

    logic               r_v1;
    logic signed [31:0] r_prod_x [4];
    logic signed [31:0] r_prod_y [4];
    logic signed [31:0] r_prod_w [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_prod_x[i] <= w_p[i] * $signed(r_row[i][15:0]);
            r_prod_y[i] <= w_p[i] * $signed(r_row[i][31:16]);
            r_prod_w[i] <= w_p[i] * $signed(r_row[i][63:48]);
        end
    end

    // Stage 2: column sums.
    logic                r_v2;
    logic signed [TW-1:0] r_t0;
    logic signed [TW-1:0] r_t1;
    logic signed [TW-1:0] r_t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t0 <= TW'(r_prod_x[0]) + TW'(r_prod_x[1]) + TW'(r_prod_x[2]) + TW'(r_prod_x[3]);
        r_t1 <= TW'(r_prod_y[0]) + TW'(r_prod_y[1]) + TW'(r_prod_y[2]) + TW'(r_prod_y[3]);
        r_t3 <= TW'(r_prod_w[0]) + TW'(r_prod_w[1]) + TW'(r_prod_w[2]) + TW'(r_prod_w[3]);
    end

    // Stage 3: magnitudes and scaling by the half extents.
    logic [TW-2:0] w_abs0;
    logic [TW-2:0] w_abs1;
    logic [TW-2:0] w_abs3;
    assign w_abs0 = r_t0[TW-1] ? (TW-1)'(-r_t0) : (TW-1)'(r_t0);
    assign w_abs1 = r_t1[TW-1] ? (TW-1)'(-r_t1) : (TW-1)'(r_t1);
    assign w_abs3 = r_t3[TW-1] ? (TW-1)'(-r_t3) : (TW-1)'(r_t3);

    logic          r_v3;
    logic [47:0]   r_ax;
    logic [47:0]   r_ay;
    logic [TW-2:0] r_b;
    logic          r_neg_x3;
    logic          r_neg_y3;
    logic          r_zero3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax     <= w_hw * w_abs0;
        r_ay     <= w_hh * w_abs1;
        r_b      <= w_abs3;
        r_neg_x3 <= r_t0[TW-1] ^ r_t3[TW-1];
        r_neg_y3 <= r_t1[TW-1] ^ r_t3[TW-1];
        r_zero3  <= (r_t3 == '0);
    end

    // Stage 4: rounded dividend 2a+b over 2b, with quotient overflow check.
    logic [NW-1:0] w_nx;
    logic [NW-1:0] w_ny;
    logic [DW-1:0] w_d;
    logic [NW-1:0] w_dtop;
    assign w_nx   = NW'({r_ax, 1'b0}) + NW'(r_b);
    assign w_ny   = NW'({r_ay, 1'b0}) + NW'(r_b);
    assign w_d    = {r_b, 1'b0};
    assign w_dtop = {w_d, {DS{1'b0}}};

    vtw_pkg::t_div r_div [DS+1];
    logic          r_dv  [DS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div[0].zero  <= r_zero3;
        r_div[0].neg_x <= r_neg_x3;
        r_div[0].neg_y <= r_neg_y3;
        r_div[0].ovf_x <= (w_nx >= w_dtop);
        r_div[0].ovf_y <= (w_ny >= w_dtop);
        r_div[0].rem_x <= w_nx;
        r_div[0].rem_y <= w_ny;
        r_div[0].den   <= w_d;
        r_div[0].q_x   <= '0;
        r_div[0].q_y   <= '0;
    end

    // Divider: stage s settles quotient bit DS-s.
    for (genvar s = 1; s <= DS; s++) begin : g_div
        localparam int K = DS - s;
        logic [NW-1:0]       w_dk;
        logic                w_gx;
        logic                w_gy;
        vtw_pkg::t_div       w_nxt;

        assign w_dk = NW'(r_div[s-1].den) << K;
        assign w_gx = r_div[s-1].rem_x >= w_dk;
        assign w_gy = r_div[s-1].rem_y >= w_dk;

        always_comb begin
            w_nxt = r_div[s-1];
            if (w_gx) begin
                w_nxt.rem_x  = r_div[s-1].rem_x - w_dk;
                w_nxt.q_x[K] = 1'b1;
            end
            if (w_gy) begin
                w_nxt.rem_y  = r_div[s-1].rem_y - w_dk;
                w_nxt.q_y[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else begin
                r_dv[s] <= r_dv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[s] <= w_nxt;
        end
    end

    // Output stage: sign, window offset, clamping and the zero w case.
    vtw_pkg::t_div      w_f;
    logic [DS:0]        w_qx;
    logic [DS:0]        w_qy;
    logic signed [22:0] w_sx;
    logic signed [22:0] w_sy;
    logic signed [22:0] w_offx;
    logic signed [22:0] w_offy;
    logic signed [22:0] w_x;
    logic signed [22:0] w_y;
    logic               w_sat_x;
    logic               w_sat_y;
    logic signed [17:0] w_cx;
    logic signed [17:0] w_cy;

    assign w_f    = r_div[DS];
    assign w_qx   = w_f.ovf_x ? (DS+1)'(1) << DS : {1'b0, w_f.q_x};
    assign w_qy   = w_f.ovf_y ? (DS+1)'(1) << DS : {1'b0, w_f.q_y};
    assign w_sx   = w_f.neg_x ? -$signed(23'(w_qx)) : $signed(23'(w_qx));
    assign w_sy   = w_f.neg_y ? $signed(23'(w_qy)) : -$signed(23'(w_qy));
    assign w_offx = (23'(r_left) <<< 4) + $signed(23'(w_hw));
    assign w_offy = (23'(r_bottom) <<< 4) - $signed(23'(w_hh));
    assign w_x    = w_sx + w_offx;
    assign w_y    = w_sy + w_offy;

    always_comb begin
        w_sat_x = 1'b1;
        w_sat_y = 1'b1;
        if (w_x > vtw_pkg::OUT_MAX) begin
            w_cx = 18'(vtw_pkg::OUT_MAX);
        end else if (w_x < vtw_pkg::OUT_MIN) begin
            w_cx = 18'(vtw_pkg::OUT_MIN);
        end else begin
            w_cx    = w_x[17:0];
            w_sat_x = 1'b0;
        end
        if (w_y > vtw_pkg::OUT_MAX) begin
            w_cy = 18'(vtw_pkg::OUT_MAX);
        end else if (w_y < vtw_pkg::OUT_MIN) begin
            w_cy = 18'(vtw_pkg::OUT_MIN);
        end else begin
            w_cy    = w_y[17:0];
            w_sat_y = 1'b0;
        end
    end

    logic               r_out_v;
    logic signed [17:0] r_win_x;
    logic signed [17:0] r_win_y;
    vtw_pkg::t_status   r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_dv[DS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f.zero) begin
            r_win_x  <= '0;
            r_win_y  <= '0;
            r_status <= vtw_pkg::ST_WZERO;
        end else begin
            r_win_x  <= w_cx;
            r_win_y  <= w_cy;
            r_status <= (w_sat_x || w_sat_y) ? vtw_pkg::ST_SAT : vtw_pkg::ST_OK;
        end
    end

    assign o_done   = r_out_v;
    assign o_win_x  = r_win_x;
    assign o_win_y  = r_win_y;
    assign o_status = r_status;

    `VTW_ASSERT_IMP(a_done_follows_start, i_clk, i_rst_n, o_done,
        $past(start && i_rst_n, vtw_pkg::LATENCY), "Result without an accepted item.")
    `VTW_ASSERT_IMP(a_wzero_clears, i_clk, i_rst_n, o_done && (o_status == vtw_pkg::ST_WZERO),
        (o_win_x == '0) && (o_win_y == '0), "Zero w result is not cleared.")
    `VTW_ASSERT_IMP(a_sat_at_bound, i_clk, i_rst_n, o_done && (o_status == vtw_pkg::ST_SAT),
        (o_win_x == 18'(vtw_pkg::OUT_MAX)) || (o_win_x == 18'(vtw_pkg::OUT_MIN)) ||
        (o_win_y == 18'(vtw_pkg::OUT_MAX)) || (o_win_y == 18'(vtw_pkg::OUT_MIN)),
        "Saturated status without a clamped coordinate.")
    `VTW_ASSERT_NXT(a_start_enters, i_clk, i_rst_n, start, r_v1,
        "Accepted item did not enter the pipeline.")

endmodule

`default_nettype wire

// ===== dv/vtw_window_checker.sv =====
// Checker that predicts window coordinates of each point and compares the results.
module vtw_window_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    input  logic signed [15:0] i_pz,
    input  logic signed [15:0] i_pw,
    input  logic               o_done,
    input  logic signed [17:0] o_win_x,
    input  logic signed [17:0] o_win_y,
    input  logic [1:0]         o_status,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [17:0] win_x;
        logic signed [17:0] win_y;
        vtw_pkg::t_status   status;
    } t_window;

    logic [63:0]        matrix_rows [4];
    logic [11:0]        view_w;
    logic [11:0]        view_h;
    logic signed [12:0] left_px;
    logic signed [12:0] bottom_px;
    t_window            window_q [$];

    assign pending = window_q.size();

    function automatic longint round_quotient(longint num, longint den);
        longint a;
        longint b;
        longint q;
        bit     neg;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        q = (2 * a + b) / (2 * b);
        return neg ? -q : q;
    endfunction

    function automatic longint clamp18(longint v, ref bit sat);
        if (v > vtw_pkg::OUT_MAX) begin
            sat = 1'b1;
            return vtw_pkg::OUT_MAX;
        end
        if (v < vtw_pkg::OUT_MIN) begin
            sat = 1'b1;
            return vtw_pkg::OUT_MIN;
        end
        return v;
    endfunction

    function automatic t_window predict_window(logic signed [15:0] px, logic signed [15:0] py,
                                               logic signed [15:0] pz, logic signed [15:0] pw);
        longint  p [4];
        longint  t [4];
        longint  hw;
        longint  hh;
        longint  x;
        longint  y;
        bit      sat;
        t_window r;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        p[3] = pw;
        sat = 1'b0;
        for (int j = 0; j < 4; j++) begin
            t[j] = 0;
            for (int i = 0; i < 4; i++) begin
                t[j] += p[i] * longint'($signed(matrix_rows[i][16*j +: 16]));
            end
        end
        if (t[3] == 0) begin
            r.win_x = '0;
            r.win_y = '0;
            r.status = vtw_pkg::ST_WZERO;
        end else begin
            hw = longint'(view_w) * 8;
            hh = longint'(view_h) * 8;
            x = round_quotient(hw * t[0], t[3]) + longint'(left_px) * 16 + hw;
            y = -round_quotient(hh * t[1], t[3]) + longint'(bottom_px) * 16 - hh;
            x = clamp18(x, sat);
            y = clamp18(y, sat);
            r.win_x = x[17:0];
            r.win_y = y[17:0];
            r.status = sat ? vtw_pkg::ST_SAT : vtw_pkg::ST_OK;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_window exp_w;
        if (!i_rst_n) begin
            matrix_rows[0] <= 64'(vtw_pkg::COEF_ONE);
            matrix_rows[1] <= 64'(vtw_pkg::COEF_ONE) << 16;
            matrix_rows[2] <= 64'(vtw_pkg::COEF_ONE) << 32;
            matrix_rows[3] <= 64'(vtw_pkg::COEF_ONE) << 48;
            view_w <= 12'd640;
            view_h <= 12'd480;
            left_px <= '0;
            bottom_px <= '0;
            errors <= 0;
            window_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (vtw_pkg::t_reg_idx'(paddr[5:3]))
                    vtw_pkg::REG_ROW0: matrix_rows[0] <= pwdata;
                    vtw_pkg::REG_ROW1: matrix_rows[1] <= pwdata;
                    vtw_pkg::REG_ROW2: matrix_rows[2] <= pwdata;
                    vtw_pkg::REG_ROW3: matrix_rows[3] <= pwdata;
                    vtw_pkg::REG_WIDTH: view_w <= pwdata[11:0];
                    vtw_pkg::REG_HEIGHT: view_h <= pwdata[11:0];
                    vtw_pkg::REG_LEFT: left_px <= pwdata[12:0];
                    vtw_pkg::REG_BOTTOM: bottom_px <= pwdata[12:0];
                    default: ;
                endcase
            end
            if (o_done) begin
                if (window_q.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d status=%0d",
                             $time, o_win_x, o_win_y, o_status);
                    errors <= errors + 1;
                end else begin
                    exp_w = window_q.pop_front();
                    if (o_win_x !== exp_w.win_x || o_win_y !== exp_w.win_y
                        || o_status !== exp_w.status) begin
                        $display("%0t: mismatch expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                                 $time, exp_w.win_x, exp_w.win_y, exp_w.status,
                                 o_win_x, o_win_y, o_status);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                window_q.push_back(predict_window(i_px, i_py, i_pz, i_pw));
            end
        end
    end

endmodule

// ===== dv/tb_vertex_to_window_transform_top.sv =====
// Testbench top that drives points and register settings into the window transform.
module tb_vertex_to_window_transform_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [15:0] i_px;
    logic signed [15:0] i_py;
    logic signed [15:0] i_pz;
    logic signed [15:0] i_pw;
    logic               o_done;
    logic signed [17:0] o_win_x;
    logic signed [17:0] o_win_y;
    logic [1:0]         o_status;
    int                 errors;
    int                 pending;
    int                 idle_pct;

    vertex_to_window_transform_top dut (.*);

    vtw_window_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    task automatic write_reg(vtw_pkg::t_reg_idx idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_px <= x;
        i_py <= y;
        i_pz <= z;
        i_pw <= w;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (vtw_pkg::LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] near_coef(int spread);
        return 16'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic random_config(int mode);
        logic [63:0] row;
        for (int i = 0; i < 4; i++) begin
            if (mode == 0) begin
                row = {$urandom, $urandom};
            end else begin
                row = '0;
                for (int j = 0; j < 4; j++) begin
                    row[16*j +: 16] = near_coef(600)
                                      + ((i == j) ? vtw_pkg::COEF_ONE : 16'd0);
                end
            end
            write_reg(vtw_pkg::t_reg_idx'(i), row);
        end
        write_reg(vtw_pkg::REG_WIDTH, {$urandom, $urandom});
        write_reg(vtw_pkg::REG_HEIGHT, {$urandom, $urandom});
        write_reg(vtw_pkg::REG_LEFT, {$urandom, $urandom});
        write_reg(vtw_pkg::REG_BOTTOM, {$urandom, $urandom});
    endtask

    task automatic random_points(int count);
        logic [15:0] w;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 7) begin
                w = 16'($urandom_range(32767, 2048));
                send_point(16'($signed(w) - $signed(16'($urandom_range(2 * w)))),
                           16'($signed(w) - $signed(16'($urandom_range(2 * w)))),
                           16'($urandom), w);
            end else begin
                send_point(16'($urandom), 16'($urandom), 16'($urandom),
                           ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        i_px = '0;
        i_py = '0;
        i_pz = '0;
        i_pw = '0;
        idle_pct = 28;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point(16'd0, 16'd0, 16'd0, 16'd16384);
        send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'd16384);
        send_point(16'h8000, 16'h8000, 16'h8000, 16'd16384);
        send_point(16'd100, 16'd100, 16'd5, 16'd0);
        send_point(16'h7fff, 16'h8000, 16'd0, 16'h8000);
        send_point(16'h7fff, 16'h7fff, 16'd0, 16'd1);
        send_point(16'h8000, 16'h7fff, 16'd0, 16'hffff);
        send_point(16'd1, 16'd1, 16'd0, 16'd10240);
        send_point(16'hffff, 16'hffff, 16'd0, 16'd10240);
        send_point(16'd1, 16'hffff, 16'd0, 16'd7680);
        send_point(16'h5555, 16'haaaa, 16'h5555, 16'h7fff);
        drain();

        write_reg(vtw_pkg::REG_ROW0, 64'h8000_7fff_8000_7fff);
        write_reg(vtw_pkg::REG_ROW1, 64'h7fff_8000_7fff_8000);
        write_reg(vtw_pkg::REG_ROW2, 64'hffff_0000_ffff_0001);
        write_reg(vtw_pkg::REG_ROW3, 64'h0800_0000_0000_0000);
        write_reg(vtw_pkg::REG_WIDTH, 64'hffff_ffff_ffff_ffff);
        write_reg(vtw_pkg::REG_HEIGHT, 64'd4095);
        write_reg(vtw_pkg::REG_LEFT, 64'h1000);
        write_reg(vtw_pkg::REG_BOTTOM, 64'h0fff);
        send_point(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        send_point(16'd0, 16'd0, 16'd0, 16'd1);
        send_point(16'd3, 16'hfffd, 16'd0, 16'd16384);
        drain();

        write_reg(vtw_pkg::REG_WIDTH, 64'd0);
        write_reg(vtw_pkg::REG_HEIGHT, 64'd0);
        write_reg(vtw_pkg::REG_LEFT, 64'h0fff);
        write_reg(vtw_pkg::REG_BOTTOM, 64'h1000);
        send_point(16'h7fff, 16'h7fff, 16'd0, 16'd1);
        send_point(16'd0, 16'd0, 16'd0, 16'd0);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            idle_pct = (phase < 4) ? 28 : (phase < 8) ? 86 : 0;
            random_config((phase % 3 == 2) ? 0 : 1);
            random_points(104);
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
